// File: design/bspt_pkg.sv
// Package for the bidirectional sorted pair table.
// Holds sizes, request and status codes, and the sequencer state type.
// No dependencies.
package bspt_pkg;

    localparam int TABLE_ENTRIES = 262144;
    localparam int ID_BITS       = 24;
    localparam int FLAG_BITS     = 40;
    localparam int ADDR_BITS     = $clog2(TABLE_ENTRIES);
    localparam int CNT_BITS      = ADDR_BITS + 1;
    localparam int KEY_BITS      = 2 * ID_BITS;
    localparam int WORD_BITS     = KEY_BITS + FLAG_BITS;
    localparam int REQ_BITS      = 3;
    localparam int STATUS_BITS   = 2;
    localparam int INDEX_BITS    = 18;
    localparam int RANGE_BITS    = 19;

    localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_DLOOK  = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_RLOOK  = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_PAIR   = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_READ   = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ISSUE,
        S_CMP,
        S_DONE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_READ_WAIT,
        S_RESP
    } seq_state_t;

endpackage

// File: design/bspt_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic; no package dependency.
module bspt_ram #(
    parameter int DEPTH     = 16,
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/bidirectional_sorted_pair_table.sv
// Bidirectional sorted pair table: top level with the request sequencer.
// Uses bspt_pkg and two bspt_ram instances (source- and target-ordered copies).
//
// One request is in work at a time; s_ready is high only while the sequencer is
// idle, and a finished result waits in the output register while the next
// request is taken. Each copy has a single read port, so a binary search step
// is a read state (S_ISSUE) then a compare state (S_CMP). A lookup runs two
// searches on one copy back to back. A pair test is one search plus a read. An
// insert runs one search on both copies together, then moves the tail up by one
// entry, reading then writing each entry, from the end down to the lower of the
// two insert positions, and then writes the new entry into both copies.
module bidirectional_sorted_pair_table (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [bspt_pkg::REQ_BITS-1:0]         s_req_type,
    input  logic [bspt_pkg::ID_BITS-1:0]          s_first_id,
    input  logic [bspt_pkg::ID_BITS-1:0]          s_second_id,
    input  logic [bspt_pkg::FLAG_BITS-1:0]        s_entry_flags,
    input  logic [bspt_pkg::INDEX_BITS-1:0]       s_entry_index,
    input  logic                                  s_use_direct,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [bspt_pkg::STATUS_BITS-1:0]      m_status,
    output logic [bspt_pkg::RANGE_BITS-1:0]       m_range_begin,
    output logic [bspt_pkg::RANGE_BITS-1:0]       m_range_end,
    output logic                                  m_pair_found,
    output logic [bspt_pkg::ID_BITS-1:0]          m_other_id,
    output logic [bspt_pkg::FLAG_BITS-1:0]        m_flags_out
);
    import bspt_pkg::*;

    seq_state_t state_reg, state_next;

    logic [REQ_BITS-1:0]   req_reg, req_next;
    logic [ID_BITS-1:0]    first_reg, first_next;
    logic [ID_BITS-1:0]    second_reg, second_next;
    logic [FLAG_BITS-1:0]  flags_reg, flags_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic                  dir_reg, dir_next;

    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [CNT_BITS-1:0]   lo0_reg, lo0_next, hi0_reg, hi0_next;
    logic [CNT_BITS-1:0]   lo1_reg, lo1_next, hi1_reg, hi1_next;
    logic [KEY_BITS-1:0]   key0_reg, key0_next, key1_reg, key1_next;
    logic                  after_reg, after_next;
    logic                  lead_reg, lead_next;
    logic                  phase_reg, phase_next;
    logic [CNT_BITS-1:0]   j_reg, j_next;

    logic [STATUS_BITS-1:0] rs_status_reg, rs_status_next;
    logic [RANGE_BITS-1:0]  rs_rb_reg, rs_rb_next, rs_re_reg, rs_re_next;
    logic                   rs_found_reg, rs_found_next;
    logic [ID_BITS-1:0]     rs_other_reg, rs_other_next;
    logic [FLAG_BITS-1:0]   rs_flags_reg, rs_flags_next;

    logic                   m_valid_reg, m_valid_next;
    logic [STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic [RANGE_BITS-1:0]  m_rb_reg, m_rb_next, m_re_reg, m_re_next;
    logic                   m_found_reg, m_found_next;
    logic [ID_BITS-1:0]     m_other_reg, m_other_next;
    logic [FLAG_BITS-1:0]   m_flags_reg, m_flags_next;

    logic                  we0, we1, re0, re1;
    logic [ADDR_BITS-1:0]  wa0, wa1, ra0, ra1;
    logic [WORD_BITS-1:0]  wd0, wd1, rd0, rd1;

    logic [CNT_BITS-1:0]   mid0, mid1, min_pos, jm1, lane_lo;
    logic                  act0, act1, right0, right1;
    logic [KEY_BITS-1:0]   cmp0, cmp1;

    bspt_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(WORD_BITS), .ADDR_BITS(ADDR_BITS)) u_src_ram (
        .aclk(aclk), .we(we0), .waddr(wa0), .wdata(wd0), .re(re0), .raddr(ra0), .rdata(rd0)
    );

    bspt_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(WORD_BITS), .ADDR_BITS(ADDR_BITS)) u_tgt_ram (
        .aclk(aclk), .we(we1), .waddr(wa1), .wdata(wd1), .re(re1), .raddr(ra1), .rdata(rd1)
    );

    assign mid0    = lo0_reg + ((hi0_reg - lo0_reg) >> 1);
    assign mid1    = lo1_reg + ((hi1_reg - lo1_reg) >> 1);
    assign act0    = lo0_reg < hi0_reg;
    assign act1    = lo1_reg < hi1_reg;
    assign min_pos = (lo0_reg < lo1_reg) ? lo0_reg : lo1_reg;
    assign jm1     = j_reg - CNT_BITS'(1);
    assign lane_lo = (req_reg == REQ_DLOOK) ? lo0_reg : lo1_reg;

    // Lead-only compare looks at the upper id of the stored key.
    assign cmp0   = lead_reg ? {{ID_BITS{1'b0}}, rd0[WORD_BITS-1 -: ID_BITS]}
                             : rd0[WORD_BITS-1 -: KEY_BITS];
    assign cmp1   = lead_reg ? {{ID_BITS{1'b0}}, rd1[WORD_BITS-1 -: ID_BITS]}
                             : rd1[WORD_BITS-1 -: KEY_BITS];
    assign right0 = after_reg ? (cmp0 <= key0_reg) : (cmp0 < key0_reg);
    assign right1 = after_reg ? (cmp1 <= key1_reg) : (cmp1 < key1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        first_reg     <= first_next;
        second_reg    <= second_next;
        flags_reg     <= flags_next;
        idx_reg       <= idx_next;
        dir_reg       <= dir_next;
        lo0_reg       <= lo0_next;
        hi0_reg       <= hi0_next;
        lo1_reg       <= lo1_next;
        hi1_reg       <= hi1_next;
        key0_reg      <= key0_next;
        key1_reg      <= key1_next;
        after_reg     <= after_next;
        lead_reg      <= lead_next;
        phase_reg     <= phase_next;
        j_reg         <= j_next;
        rs_status_reg <= rs_status_next;
        rs_rb_reg     <= rs_rb_next;
        rs_re_reg     <= rs_re_next;
        rs_found_reg  <= rs_found_next;
        rs_other_reg  <= rs_other_next;
        rs_flags_reg  <= rs_flags_next;
        m_status_reg  <= m_status_next;
        m_rb_reg      <= m_rb_next;
        m_re_reg      <= m_re_next;
        m_found_reg   <= m_found_next;
        m_other_reg   <= m_other_next;
        m_flags_reg   <= m_flags_next;
    end

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        flags_next     = flags_reg;
        idx_next       = idx_reg;
        dir_next       = dir_reg;
        cnt_next       = cnt_reg;
        lo0_next       = lo0_reg;
        hi0_next       = hi0_reg;
        lo1_next       = lo1_reg;
        hi1_next       = hi1_reg;
        key0_next      = key0_reg;
        key1_next      = key1_reg;
        after_next     = after_reg;
        lead_next      = lead_reg;
        phase_next     = phase_reg;
        j_next         = j_reg;
        rs_status_next = rs_status_reg;
        rs_rb_next     = rs_rb_reg;
        rs_re_next     = rs_re_reg;
        rs_found_next  = rs_found_reg;
        rs_other_next  = rs_other_reg;
        rs_flags_next  = rs_flags_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_rb_next      = m_rb_reg;
        m_re_next      = m_re_reg;
        m_found_next   = m_found_reg;
        m_other_next   = m_other_reg;
        m_flags_next   = m_flags_reg;
        s_ready        = 1'b0;
        we0 = 1'b0; we1 = 1'b0; re0 = 1'b0; re1 = 1'b0;
        wa0 = '0;   wa1 = '0;   ra0 = '0;   ra1 = '0;
        wd0 = '0;   wd1 = '0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next       = s_req_type;
                    first_next     = s_first_id;
                    second_next    = s_second_id;
                    flags_next     = s_entry_flags;
                    idx_next       = s_entry_index;
                    dir_next       = s_use_direct;
                    rs_status_next = ST_OK;
                    rs_rb_next     = '0;
                    rs_re_next     = '0;
                    rs_found_next  = 1'b0;
                    rs_other_next  = '0;
                    rs_flags_next  = '0;
                    lo0_next = '0; hi0_next = '0; lo1_next = '0; hi1_next = '0;
                    key0_next  = {s_first_id, s_second_id};
                    key1_next  = {s_second_id, s_first_id};
                    after_next = 1'b0;
                    lead_next  = 1'b0;
                    phase_next = 1'b0;
                    state_next = S_RESP;
                    case (s_req_type)
                        REQ_CLEAR: begin
                            cnt_next = '0;
                        end
                        REQ_INSERT: begin
                            if (cnt_reg == CNT_BITS'(TABLE_ENTRIES)) begin
                                rs_status_next = ST_FULL;
                            end else begin
                                hi0_next   = cnt_reg;
                                hi1_next   = cnt_reg;
                                after_next = 1'b1;
                                state_next = S_ISSUE;
                            end
                        end
                        REQ_DLOOK: begin
                            hi0_next   = cnt_reg;
                            key0_next  = {{ID_BITS{1'b0}}, s_first_id};
                            lead_next  = 1'b1;
                            state_next = S_ISSUE;
                        end
                        REQ_RLOOK: begin
                            hi1_next   = cnt_reg;
                            key1_next  = {{ID_BITS{1'b0}}, s_second_id};
                            lead_next  = 1'b1;
                            state_next = S_ISSUE;
                        end
                        REQ_PAIR: begin
                            hi0_next   = cnt_reg;
                            state_next = S_ISSUE;
                        end
                        REQ_READ: begin
                            if ({1'b0, s_entry_index} >= cnt_reg) begin
                                rs_status_next = ST_RANGE;
                            end else begin
                                re0        = s_use_direct;
                                re1        = !s_use_direct;
                                ra0        = s_entry_index[ADDR_BITS-1:0];
                                ra1        = s_entry_index[ADDR_BITS-1:0];
                                state_next = S_READ_WAIT;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_ISSUE: begin
                if (!act0 && !act1) begin
                    state_next = S_DONE;
                end else begin
                    re0        = act0;
                    re1        = act1;
                    ra0        = mid0[ADDR_BITS-1:0];
                    ra1        = mid1[ADDR_BITS-1:0];
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (act0) begin
                    if (right0) lo0_next = mid0 + CNT_BITS'(1);
                    else        hi0_next = mid0;
                end
                if (act1) begin
                    if (right1) lo1_next = mid1 + CNT_BITS'(1);
                    else        hi1_next = mid1;
                end
                state_next = S_ISSUE;
            end
            S_DONE: begin
                case (req_reg)
                    REQ_INSERT: begin
                        j_next     = cnt_reg;
                        state_next = S_SHIFT_RD;
                    end
                    REQ_DLOOK, REQ_RLOOK: begin
                        if (!phase_reg) begin
                            // Start the upper-bound search on the same copy.
                            rs_rb_next = lane_lo;
                            phase_next = 1'b1;
                            after_next = 1'b1;
                            if (req_reg == REQ_DLOOK) begin
                                lo0_next = '0;
                                hi0_next = cnt_reg;
                            end else begin
                                lo1_next = '0;
                                hi1_next = cnt_reg;
                            end
                            state_next = S_ISSUE;
                        end else begin
                            rs_re_next = lane_lo;
                            state_next = S_RESP;
                        end
                    end
                    REQ_PAIR: begin
                        if (lo0_reg < cnt_reg) begin
                            re0        = 1'b1;
                            ra0        = lo0_reg[ADDR_BITS-1:0];
                            state_next = S_READ_WAIT;
                        end else begin
                            state_next = S_RESP;
                        end
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SHIFT_RD: begin
                if (j_reg > min_pos) begin
                    re0        = 1'b1;
                    re1        = 1'b1;
                    ra0        = jm1[ADDR_BITS-1:0];
                    ra1        = jm1[ADDR_BITS-1:0];
                    state_next = S_SHIFT_WR;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_SHIFT_WR: begin
                // Move entry j-1 up to j in each copy where j-1 is at or above its insert point.
                we0        = jm1 >= lo0_reg;
                we1        = jm1 >= lo1_reg;
                wa0        = j_reg[ADDR_BITS-1:0];
                wa1        = j_reg[ADDR_BITS-1:0];
                wd0        = rd0;
                wd1        = rd1;
                j_next     = jm1;
                state_next = S_SHIFT_RD;
            end
            S_PLACE: begin
                we0        = 1'b1;
                we1        = 1'b1;
                wa0        = lo0_reg[ADDR_BITS-1:0];
                wa1        = lo1_reg[ADDR_BITS-1:0];
                wd0        = {key0_reg, flags_reg};
                wd1        = {key1_reg, flags_reg};
                cnt_next   = cnt_reg + CNT_BITS'(1);
                state_next = S_RESP;
            end
            S_READ_WAIT: begin
                if (req_reg == REQ_PAIR) begin
                    rs_found_next = rd0[WORD_BITS-1 -: KEY_BITS] == key0_reg;
                end else if (dir_reg) begin
                    rs_other_next = rd0[FLAG_BITS +: ID_BITS];
                    rs_flags_next = rd0[FLAG_BITS-1:0];
                end else begin
                    rs_other_next = rd1[FLAG_BITS +: ID_BITS];
                    rs_flags_next = rd1[FLAG_BITS-1:0];
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = rs_status_reg;
                    m_rb_next     = rs_rb_reg;
                    m_re_next     = rs_re_reg;
                    m_found_next  = rs_found_reg;
                    m_other_next  = rs_other_reg;
                    m_flags_next  = rs_flags_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_range_begin = m_rb_reg;
    assign m_range_end   = m_re_reg;
    assign m_pair_found  = m_found_reg;
    assign m_other_id    = m_other_reg;
    assign m_flags_out   = m_flags_reg;

endmodule

// File: design/bspt_checker.sv
// Port-level checker for the bidirectional sorted pair table, with its bind.
// Uses bspt_pkg status codes; sees only the top-level ports.
module bspt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [bspt_pkg::STATUS_BITS-1:0] m_status,
    input logic [bspt_pkg::RANGE_BITS-1:0]  m_range_begin,
    input logic [bspt_pkg::RANGE_BITS-1:0]  m_range_end,
    input logic                             m_pair_found,
    input logic [bspt_pkg::ID_BITS-1:0]     m_other_id,
    input logic [bspt_pkg::FLAG_BITS-1:0]   m_flags_out
);
    import bspt_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_range_begin)
                                && $stable(m_range_end) && $stable(m_flags_out))
        else $error("result changed while stalled");

    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_range_begin <= m_range_end)
        else $error("range begin above range end");

    a_range_err_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_RANGE |-> m_other_id == '0 && m_flags_out == '0)
        else $error("out of range read returned data");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == ST_OK || m_status == ST_FULL || m_status == ST_RANGE)
        else $error("bad status code");

    a_full_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> !m_pair_found && m_range_end == '0)
        else $error("full status with result data");

endmodule

bind bidirectional_sorted_pair_table bspt_checker u_bspt_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_range_begin(m_range_begin), .m_range_end(m_range_end),
    .m_pair_found(m_pair_found), .m_other_id(m_other_id), .m_flags_out(m_flags_out)
);

// File: tb/bidirectional_sorted_pair_table_checker.sv
`timescale 1ns / 100ps
// Checker for the bidirectional sorted pair table: watches both channels,
// keeps its own sorted copies of the table and compares every response.
// Depends on bspt_pkg.
module bidirectional_sorted_pair_table_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic [bspt_pkg::REQ_BITS-1:0]         s_req_type,
    input  logic [bspt_pkg::ID_BITS-1:0]          s_first_id,
    input  logic [bspt_pkg::ID_BITS-1:0]          s_second_id,
    input  logic [bspt_pkg::FLAG_BITS-1:0]        s_entry_flags,
    input  logic [bspt_pkg::INDEX_BITS-1:0]       s_entry_index,
    input  logic                                  s_use_direct,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [bspt_pkg::STATUS_BITS-1:0]      m_status,
    input  logic [bspt_pkg::RANGE_BITS-1:0]       m_range_begin,
    input  logic [bspt_pkg::RANGE_BITS-1:0]       m_range_end,
    input  logic                                  m_pair_found,
    input  logic [bspt_pkg::ID_BITS-1:0]          m_other_id,
    input  logic [bspt_pkg::FLAG_BITS-1:0]        m_flags_out,
    output int                                    fail_count,
    output int                                    pending
);
    import bspt_pkg::*;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [RANGE_BITS-1:0]  range_begin;
        logic [RANGE_BITS-1:0]  range_end;
        logic                   pair_found;
        logic [ID_BITS-1:0]     other_id;
        logic [FLAG_BITS-1:0]   flags_out;
    } response_t;

    logic [KEY_BITS-1:0]  src_keys[$];
    logic [FLAG_BITS-1:0] src_flags[$];
    logic [KEY_BITS-1:0]  tgt_keys[$];
    logic [FLAG_BITS-1:0] tgt_flags[$];
    response_t            expected_responses[$];

    // Insert after every equal key.
    function automatic void place_sorted(ref logic [KEY_BITS-1:0] keys[$],
                                         ref logic [FLAG_BITS-1:0] flags[$],
                                         input logic [KEY_BITS-1:0] key,
                                         input logic [FLAG_BITS-1:0] fl);
        int pos;
        pos = 0;
        while (pos < keys.size() && keys[pos] <= key)
            pos++;
        keys.insert(pos, key);
        flags.insert(pos, fl);
    endfunction

    function automatic void lead_range(input logic [KEY_BITS-1:0] keys[$],
                                       input logic [ID_BITS-1:0] lead,
                                       output logic [RANGE_BITS-1:0] rb,
                                       output logic [RANGE_BITS-1:0] re);
        rb = 0;
        re = 0;
        foreach (keys[i]) begin
            if (keys[i][KEY_BITS-1:ID_BITS] < lead)
                rb++;
            if (keys[i][KEY_BITS-1:ID_BITS] <= lead)
                re++;
        end
    endfunction

    function automatic response_t table_response();
        response_t r;
        r = '0;
        case (s_req_type)
            REQ_CLEAR: begin
                src_keys.delete();
                src_flags.delete();
                tgt_keys.delete();
                tgt_flags.delete();
            end
            REQ_INSERT: begin
                if (src_keys.size() >= TABLE_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    place_sorted(src_keys, src_flags, {s_first_id, s_second_id},
                                 s_entry_flags);
                    place_sorted(tgt_keys, tgt_flags, {s_second_id, s_first_id},
                                 s_entry_flags);
                end
            end
            REQ_DLOOK: lead_range(src_keys, s_first_id, r.range_begin, r.range_end);
            REQ_RLOOK: lead_range(tgt_keys, s_second_id, r.range_begin, r.range_end);
            REQ_PAIR: begin
                foreach (src_keys[i])
                    if (src_keys[i] == {s_first_id, s_second_id})
                        r.pair_found = 1'b1;
            end
            REQ_READ: begin
                if (s_entry_index >= src_keys.size()) begin
                    r.status = ST_RANGE;
                end else if (s_use_direct) begin
                    r.other_id  = src_keys[s_entry_index][ID_BITS-1:0];
                    r.flags_out = src_flags[s_entry_index];
                end else begin
                    r.other_id  = tgt_keys[s_entry_index][ID_BITS-1:0];
                    r.flags_out = tgt_flags[s_entry_index];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        response_t e;
        if (!aresetn) begin
            src_keys.delete();
            src_flags.delete();
            tgt_keys.delete();
            tgt_flags.delete();
            expected_responses.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_responses.size() == 0) begin
                    $error("unexpected response transaction");
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_responses.pop_front();
                    if (e.status !== m_status ||
                        e.range_begin !== m_range_begin ||
                        e.range_end !== m_range_end ||
                        e.pair_found !== m_pair_found ||
                        e.other_id !== m_other_id ||
                        e.flags_out !== m_flags_out)
                        fail_count <= fail_count + 1;
                    if (e.status !== m_status)
                        $error("status: expected %0d, actual %0d", e.status, m_status);
                    if (e.range_begin !== m_range_begin)
                        $error("range_begin: expected %0d, actual %0d",
                               e.range_begin, m_range_begin);
                    if (e.range_end !== m_range_end)
                        $error("range_end: expected %0d, actual %0d",
                               e.range_end, m_range_end);
                    if (e.pair_found !== m_pair_found)
                        $error("pair_found: expected %0d, actual %0d",
                               e.pair_found, m_pair_found);
                    if (e.other_id !== m_other_id)
                        $error("other_id: expected %h, actual %h", e.other_id, m_other_id);
                    if (e.flags_out !== m_flags_out)
                        $error("flags_out: expected %h, actual %h",
                               e.flags_out, m_flags_out);
                end
            end
            if (s_valid && s_ready)
                expected_responses.push_back(table_response());
            pending <= expected_responses.size();
        end
    end

endmodule

// File: tb/bidirectional_sorted_pair_table_test.sv
`timescale 1ns / 100ps
// Top of the pair table testbench: clock, reset, request stimulus, response
// back-pressure, watchdog and verdict. Uses bspt_pkg and the checker module.
module bidirectional_sorted_pair_table_test;
    import bspt_pkg::*;

    localparam logic [REQ_BITS-1:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [REQ_BITS-1:0] REQ_UNUSED_HI = 3'd7;
    localparam int RANDOM_ITEMS = 1630;
    localparam int QUIET_ITEMS  = 150;
    localparam int STALL_LIMIT  = 20000;
    localparam logic [ID_BITS-1:0] ID_MAX = '1;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [REQ_BITS-1:0]    s_req_type = REQ_CLEAR;
    logic [ID_BITS-1:0]     s_first_id = '0;
    logic [ID_BITS-1:0]     s_second_id = '0;
    logic [FLAG_BITS-1:0]   s_entry_flags = '0;
    logic [INDEX_BITS-1:0]  s_entry_index = '0;
    logic                   s_use_direct = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [STATUS_BITS-1:0] m_status;
    logic [RANGE_BITS-1:0]  m_range_begin;
    logic [RANGE_BITS-1:0]  m_range_end;
    logic                   m_pair_found;
    logic [ID_BITS-1:0]     m_other_id;
    logic [FLAG_BITS-1:0]   m_flags_out;
    int                     fail_count;
    int                     pending;
    bit                     quiet = 1'b0;
    int                     idle_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bidirectional_sorted_pair_table i_dut (.*);

    bidirectional_sorted_pair_table_checker i_checker (.*);

    // Abort when no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[bidirectional_sorted_pair_table] ERROR");
            $finish;
        end
    end

    // Response back-pressure in random bursts.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    task automatic send_request(input logic [REQ_BITS-1:0] req,
                                input logic [ID_BITS-1:0] src,
                                input logic [ID_BITS-1:0] tgt,
                                input logic [FLAG_BITS-1:0] fl,
                                input logic [INDEX_BITS-1:0] idx,
                                input logic direct);
        if (!quiet && $urandom_range(0, 9) < 3) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_first_id    <= src;
        s_second_id   <= tgt;
        s_entry_flags <= fl;
        s_entry_index <= idx;
        s_use_direct  <= direct;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mostly a small pool so that keys collide.
    function automatic logic [ID_BITS-1:0] pick_id();
        case ($urandom_range(0, 9))
            0: return ID_BITS'($urandom);
            1: return ID_MAX;
            2: return '0;
            default: return ID_BITS'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [FLAG_BITS-1:0] pick_flags();
        return FLAG_BITS'({$urandom, $urandom});
    endfunction

    initial begin
        int r;
        logic [REQ_BITS-1:0] req;
        logic [INDEX_BITS-1:0] idx;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table first.
        send_request(REQ_DLOOK, 24'd5, '0, '0, '0, 1'b0);
        send_request(REQ_RLOOK, '0, 24'd7, '0, '0, 1'b0);
        send_request(REQ_PAIR, 24'd5, 24'd7, '0, '0, 1'b0);
        send_request(REQ_READ, '0, '0, '0, '0, 1'b1);
        send_request(REQ_INSERT, '0, '0, '0, '0, 1'b0);
        send_request(REQ_INSERT, ID_MAX, ID_MAX, '1, '0, 1'b0);
        send_request(REQ_INSERT, 24'd5, 24'd7, 40'h01_0203_0405, '0, 1'b0);
        send_request(REQ_INSERT, 24'd5, 24'd7, 40'hA0_B0C0_D0E0, '0, 1'b0);
        send_request(REQ_INSERT, 24'd5, 24'd3, 40'h55_5555_5555, '0, 1'b0);
        send_request(REQ_DLOOK, 24'd5, '0, '0, '0, 1'b0);
        send_request(REQ_DLOOK, ID_MAX, '0, '0, '0, 1'b0);
        send_request(REQ_RLOOK, '0, 24'd7, '0, '0, 1'b0);
        send_request(REQ_RLOOK, '0, 24'd6, '0, '0, 1'b0);
        send_request(REQ_PAIR, 24'd5, 24'd3, '0, '0, 1'b0);
        send_request(REQ_PAIR, 24'd3, 24'd5, '0, '0, 1'b0);
        send_request(REQ_READ, '0, '0, '0, 18'd0, 1'b1);
        send_request(REQ_READ, '0, '0, '0, 18'd4, 1'b0);
        send_request(REQ_READ, '0, '0, '0, 18'd2, 1'b0);
        send_request(REQ_READ, '0, '0, '0, 18'd5, 1'b1);
        send_request(REQ_READ, '0, '0, '0, '1, 1'b0);
        send_request(REQ_UNUSED_LO, ID_MAX, ID_MAX, '1, '1, 1'b1);
        send_request(REQ_UNUSED_HI, ID_MAX, ID_MAX, '1, '1, 1'b1);
        send_request(REQ_CLEAR, '0, '0, '0, '0, 1'b0);
        send_request(REQ_READ, '0, '0, '0, 18'd0, 1'b1);

        // Hold until the directed part has drained.
        s_valid <= 1'b0;
        @(posedge aclk iff pending == 0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 2)
                req = REQ_CLEAR;
            else if (r < 36)
                req = REQ_INSERT;
            else if (r < 50)
                req = REQ_DLOOK;
            else if (r < 62)
                req = REQ_RLOOK;
            else if (r < 77)
                req = REQ_PAIR;
            else if (r < 96)
                req = REQ_READ;
            else
                req = REQ_BITS'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            idx = ($urandom_range(0, 9) == 0) ? INDEX_BITS'($urandom)
                                                : INDEX_BITS'($urandom_range(0, 40));
            send_request(req, pick_id(), pick_id(), pick_flags(), idx,
                         1'($urandom_range(0, 1)));
        end
        s_valid <= 1'b0;

        @(posedge aclk iff pending == 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("[bidirectional_sorted_pair_table] OK");
        else
            $display("[bidirectional_sorted_pair_table] ERROR");
        $finish;
    end

endmodule
